// ===== rtl/core/mm_pkg.sv =====
package mm_pkg;

  // default largest matrix dimension
  localparam int unsigned MAX_DIM_DEF = 8;

  localparam int unsigned DIM_W     = 4;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned ACC_W     = 36;
  localparam int unsigned CFG_IDX_W = 2;

  // item opcodes
  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [ELEM_W-1:0] element;
  } mm_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [PROD_W-1:0] product;
    logic                     last;
    logic                     range_error;
  } mm_result_t;

  // tag that travels with one multiply-accumulate step
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last_all;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mm_tag_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > max_dim) begin
      r = max_dim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mm_ram.sv =====
module mm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/mm_mac.sv =====
module mm_mac (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  mm_pkg::mm_tag_t                  tag_in,
  input  logic signed [mm_pkg::ELEM_W-1:0] a,
  input  logic signed [mm_pkg::ELEM_W-1:0] b,
  output mm_pkg::mm_tag_t                  done_tag,
  output logic                             done,
  output logic signed [mm_pkg::PROD_W-1:0] sum
);
  import mm_pkg::*;

  mm_tag_t                  m_tag;
  logic signed [PROD_W-1:0] m_prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic [ACC_W-PROD_W:0]    acc_hi;

  // multiply stage, then accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tag <= '0;
    end else if (en) begin
      m_tag  <= tag_in;
      m_prod <= a * b;
      if (m_tag.valid) begin
        acc <= acc_next;
      end
    end
  end

  always_comb begin
    acc_next = (m_tag.first ? '0 : acc) + ACC_W'(m_prod);
    acc_hi   = acc_next[ACC_W-1:PROD_W-1];
    // saturate to 32 bits
    if (acc_hi == '0 || acc_hi == '1) begin
      sum = acc_next[PROD_W-1:0];
    end else if (acc_next[ACC_W-1]) begin
      sum = {1'b1, {(PROD_W-1){1'b0}}};
    end else begin
      sum = {1'b0, {(PROD_W-1){1'b1}}};
    end
  end

  assign done_tag = m_tag;
  assign done     = m_tag.valid & m_tag.last_k;

endmodule

// ===== rtl/core/matrix_multiply.sv =====
// in-range load item: written to the A or B store on acceptance, no result
// out-of-range load: one error result in the output register the cycle after acceptance
// run item: one multiply-accumulate per cycle unless the result stalls, by the single
//   shared MAC unit behind the store read; input stalled until the pipeline drains
// result stall freezes the read/multiply/accumulate pipeline in place
// synchronous reset clears control and sets all sizes to 8; stores are not cleared
module matrix_multiply #(
  parameter int unsigned MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]         cfg_data,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  mm_pkg::mm_item_t                 item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output mm_pkg::mm_result_t               result
);
  import mm_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t           state;
  logic [DIM_W-1:0] rows_a, inner_dim, cols_b;
  logic [DIM_W-1:0] nr, nk, nc;
  logic [IDX_W-1:0] ci, cj, ck;

  // control
  logic freeze;       // output register full and stalled
  logic pipe_busy;
  logic take;
  logic is_load;
  logic load_err;
  logic a_we, b_we;

  logic [DIM_W-1:0] lim_r, lim_c;
  logic [AW-1:0]    waddr, a_raddr, b_raddr;
  logic [ELEM_W-1:0] a_rdata, b_rdata;

  mm_tag_t iss_tag;   // tag of the step issued to the stores this cycle
  mm_tag_t r_tag;     // tag aligned with store read data
  mm_tag_t done_tag;
  logic    mac_done;
  logic signed [PROD_W-1:0] mac_sum;

  logic last_k, last_j, last_i;

  // effective sizes, out-of-range values saturate into 1..MAX_DIM
  assign nr = eff_dim(rows_a, DIM_MAX);
  assign nk = eff_dim(inner_dim, DIM_MAX);
  assign nc = eff_dim(cols_b, DIM_MAX);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_W'(8);
      inner_dim <= DIM_W'(8);
      cols_b    <= DIM_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        default:       ;
      endcase
    end
  end

  // load range check
  assign is_load  = (item.op == OP_LOAD_A) || (item.op == OP_LOAD_B);
  assign lim_r    = (item.op == OP_LOAD_A) ? nr : nk;
  assign lim_c    = (item.op == OP_LOAD_A) ? nk : nc;
  assign load_err = is_load && ((DIM_W'(item.row_index) >= lim_r) ||
                                (DIM_W'(item.col_index) >= lim_c));

  assign freeze    = result_valid & result_stall;
  assign pipe_busy = r_tag.valid | done_tag.valid;

  // an error item needs the output slot; in-range loads pass while a result waits
  assign item_stall = (state != ST_IDLE) | pipe_busy | (freeze & load_err);
  assign take       = item_valid & ~item_stall;

  assign a_we  = take && (item.op == OP_LOAD_A) && !load_err;
  assign b_we  = take && (item.op == OP_LOAD_B) && !load_err;
  assign waddr = AW'(item.row_index * MAX_DIM + item.col_index);

  // issue addresses: A[i][k], B[k][j]
  assign a_raddr = AW'(ci * MAX_DIM + ck);
  assign b_raddr = AW'(ck * MAX_DIM + cj);

  assign last_k = (DIM_W'(ck) == nk - DIM_W'(1));
  assign last_j = (DIM_W'(cj) == nc - DIM_W'(1));
  assign last_i = (DIM_W'(ci) == nr - DIM_W'(1));

  always_comb begin
    iss_tag.valid    = (state == ST_RUN);
    iss_tag.first    = (ck == '0);
    iss_tag.last_k   = last_k;
    iss_tag.last_all = last_i & last_j;
    iss_tag.row      = ci;
    iss_tag.col      = cj;
  end

  mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (item.element),
    .re    (~freeze),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (item.element),
    .re    (~freeze),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // tag follows the store read latency
  always_ff @(posedge clk) begin
    if (rst) begin
      r_tag <= '0;
    end else if (!freeze) begin
      r_tag <= iss_tag;
    end
  end

  mm_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .en       (~freeze),
    .tag_in   (r_tag),
    .a        (a_rdata),
    .b        (b_rdata),
    .done_tag (done_tag),
    .done     (mac_done),
    .sum      (mac_sum)
  );

  // sequencer, index counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ci           <= '0;
      cj           <= '0;
      ck           <= '0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (take && item.op == OP_RUN) begin
            state <= ST_RUN;
            ci    <= '0;
            cj    <= '0;
            ck    <= '0;
          end
        end
        ST_RUN: begin
          if (!freeze) begin
            if (!last_k) begin
              ck <= ck + IDX_W'(1);
            end else begin
              ck <= '0;
              if (!last_j) begin
                cj <= cj + IDX_W'(1);
              end else begin
                cj <= '0;
                if (!last_i) begin
                  ci <= ci + IDX_W'(1);
                end else begin
                  state <= ST_IDLE;
                end
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (!freeze) begin
        if (mac_done) begin
          result_valid       <= 1'b1;
          result.out_row     <= done_tag.row;
          result.out_col     <= done_tag.col;
          result.product     <= mac_sum;
          result.last        <= done_tag.last_all;
          result.range_error <= 1'b0;
        end else if (take && load_err) begin
          result_valid       <= 1'b1;
          result.out_row     <= item.row_index;
          result.out_col     <= item.col_index;
          result.product     <= '0;
          result.last        <= 1'b1;
          result.range_error <= 1'b1;
        end else begin
          result_valid <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/core/mm_chk.sv =====
module mm_chk (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input mm_pkg::mm_item_t   item,
  input logic               result_valid,
  input logic               result_stall,
  input mm_pkg::mm_result_t result
);
  import mm_pkg::*;

  // error results are single, final and carry no product
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.range_error |-> result.last && result.product == '0)
    else $error("error result without last or with nonzero product");

  // a run keeps the input closed at least for its first step
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.op == OP_RUN |=> item_stall)
    else $error("item accepted right after a run item");

  // a stalled result is held
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind matrix_multiply mm_chk u_mm_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
